FILE: rtl/rpfc_pkg.sv
package rpfc_pkg;

  // Output format codes held in the format register.
  typedef enum logic [2:0] {
    FMT_MONO1    = 3'd0,
    FMT_YA11     = 3'd1,
    FMT_BGR565   = 3'd2,
    FMT_RGBA8888 = 3'd3,
    FMT_Y8       = 3'd4,
    FMT_BGR332   = 3'd5,
    FMT_ARGB4444 = 3'd6
  } fmt_e;

  localparam int unsigned ChanW = 8;
  localparam int unsigned SumW  = 10;
  localparam int unsigned CodeW = 32;

  // Reciprocal of three in 11 fractional bits; exact floor for sums up to 765.
  localparam int unsigned RecipShift = 11;
  localparam logic [10:0] Recip3     = 11'd683;
  localparam int unsigned ProdW      = SumW + 11;

  localparam logic [SumW-1:0]  MonoThresh = 10'd384;
  localparam logic [ChanW-1:0] YaLow      = 8'h40;
  localparam logic [ChanW-1:0] YaMid      = 8'h80;
  localparam logic [ChanW-1:0] YaHigh     = 8'hc0;
  localparam logic [15:0]      Bgr565Black = 16'h0800;
  localparam logic [7:0]       Bgr332Black = 8'h20;

  // Status that the converter hands to the flag logic.
  typedef struct packed {
    logic set_seen;
  } conv_status_t;

endpackage

FILE: rtl/rgba_pixel_format_converter_top.sv
// Pipeline: two register stages, the input register and the result register;
// a word accepted into the input register moves on into the result register.
// Throughput: one pixel per clock; the input register and the result
// register form a two-stage pipeline that stalls only when the output stalls.
// Reset: rst_ni clears valids and the alpha-seen flag and sets the format
// register to rgba8888.
module rgba_pixel_format_converter_top
  import rpfc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ChanW-1:0]  red_i,
  input  logic [ChanW-1:0]  green_i,
  input  logic [ChanW-1:0]  blue_i,
  input  logic [ChanW-1:0]  alpha_i,
  input  logic              image_start_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CodeW-1:0]  pixel_code_o,
  output logic              alpha_seen_o
);

  fmt_e             fmt_q;
  logic             s1_valid_q, s1_valid_d;
  logic [ChanW-1:0] s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q;
  logic             s1_start_q;
  logic             out_valid_q, out_valid_d;
  logic [CodeW-1:0] code_q;
  logic             seen_q, seen_d;
  logic [CodeW-1:0] conv_code;
  conv_status_t     conv_status;
  logic             advance, move, accept;

  // Format register; writes must come only while the pipeline is empty; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGBA8888;
    end else if (cfg_valid_i) begin
      fmt_q <= fmt_e'(cfg_data_i);
    end
  end

  // Pipeline handshake: the result register advances when empty or taken.
  assign advance     = ~out_valid_q | ~out_stall_i;
  assign move        = s1_valid_q & advance;
  assign in_stall_o  = s1_valid_q & ~advance;
  assign accept      = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = accept | (s1_valid_q & ~advance);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      seen_q      <= seen_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_red_q   <= red_i;
      s1_green_q <= green_i;
      s1_blue_q  <= blue_i;
      s1_alpha_q <= alpha_i;
      s1_start_q <= image_start_i;
    end
  end

  rpfc_convert u_convert (
    .fmt_i    (fmt_q),
    .red_i    (s1_red_q),
    .green_i  (s1_green_q),
    .blue_i   (s1_blue_q),
    .alpha_i  (s1_alpha_q),
    .code_o   (conv_code),
    .status_o (conv_status)
  );

  // Sticky flag follows each word as it enters the result register.
  always_comb begin
    seen_d = seen_q;
    if (move) begin
      seen_d = (seen_q & ~s1_start_q) | conv_status.set_seen;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (move) begin
      code_q <= conv_code;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_code_o = code_q;
  assign alpha_seen_o = seen_q;

`ifndef SYNTHESIS
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result word appeared without a word in the input register");

  a_seen_rises_on_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seen_q) |-> $past(move))
    else $error("alpha-seen flag set without a word moving");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && s1_start_q && !conv_status.set_seen) |=> !seen_q)
    else $error("image start did not clear the alpha-seen flag");
`endif

endmodule

FILE: rtl/rpfc_convert.sv
module rpfc_convert
  import rpfc_pkg::*;
(
  input  fmt_e              fmt_i,
  input  logic [ChanW-1:0]  red_i,
  input  logic [ChanW-1:0]  green_i,
  input  logic [ChanW-1:0]  blue_i,
  input  logic [ChanW-1:0]  alpha_i,
  output logic [CodeW-1:0]  code_o,
  output conv_status_t      status_o
);

  logic [SumW-1:0]  sum;
  logic [ProdW-1:0] prod;
  logic [ChanW-1:0] avg;
  logic [15:0]      c565;
  logic [7:0]       c332;
  logic             transp;

  // Channel sum and its average by multiplying with a reciprocal.
  assign sum  = SumW'(red_i) + SumW'(green_i) + SumW'(blue_i);
  assign prod = ProdW'(sum) * ProdW'(Recip3);
  assign avg  = prod[RecipShift +: ChanW];

  assign c565   = {blue_i[7:3], green_i[7:2], red_i[7:3]};
  assign c332   = {blue_i[7:5], green_i[7:5], red_i[7:6]};
  assign transp = ~alpha_i[7];

  // Per-format code and transparency rule.
  always_comb begin
    code_o            = '0;
    status_o.set_seen = 1'b0;
    unique case (fmt_i)
      FMT_MONO1: begin
        code_o = CodeW'(sum >= MonoThresh);
      end
      FMT_YA11: begin
        if (transp || (avg >= YaLow && avg < YaHigh)) begin
          status_o.set_seen = 1'b1;
        end else if (avg < YaMid) begin
          code_o = CodeW'(2'd1);
        end else begin
          code_o = CodeW'(2'd3);
        end
      end
      FMT_BGR565: begin
        if (transp) begin
          status_o.set_seen = 1'b1;
        end else if (c565 == '0) begin
          code_o = CodeW'(Bgr565Black);
        end else begin
          code_o = CodeW'(c565);
        end
      end
      FMT_RGBA8888: begin
        code_o            = {red_i, green_i, blue_i, alpha_i};
        status_o.set_seen = (alpha_i == '0);
      end
      FMT_Y8: begin
        code_o = CodeW'(avg);
      end
      FMT_BGR332: begin
        if (transp) begin
          status_o.set_seen = 1'b1;
        end else if (c332 == '0) begin
          code_o = CodeW'(Bgr332Black);
        end else begin
          code_o = CodeW'(c332);
        end
      end
      FMT_ARGB4444: begin
        code_o = CodeW'({alpha_i[7:4], red_i[7:4], green_i[7:4], blue_i[7:4]});
        status_o.set_seen = transp;
      end
      default: begin
        code_o = '0;
      end
    endcase
  end

endmodule

FILE: tb/rgba_pixel_format_converter_top_tb.sv
`timescale 1ns / 100ps

module rgba_pixel_format_converter_top_tb;
  import rpfc_pkg::*;

  // Format code that the register accepts but no conversion uses.
  localparam logic [2:0] FmtUnused = 3'd7;

  localparam int NumDirRows = 25;
  localparam int NumPhases = 24;
  localparam int PixelsPerPhase = 60;
  localparam int DrainCycles = 10;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        start;
    logic        has_exp;
    logic [31:0] code;
    logic        seen;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] code;
    logic        seen;
  } conv_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i = FMT_RGBA8888;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic [7:0]  alpha_i = '0;
  logic        image_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] pixel_code_o;
  logic        alpha_seen_o;

  // Predictor state: the format register and the sticky alpha flag.
  logic [2:0]  cur_format = FMT_RGBA8888;
  logic        seen_flag = 1'b0;

  conv_result_t pending_codes[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int           mismatch_count = 0;

  // Directed pixels: extremes, every format, threshold edges and the unused format.
  dir_row_t dir_rows [NumDirRows] = '{
    '{FMT_RGBA8888, 8'h12, 8'h34, 8'h56, 8'hff, 1'b1, 1'b1, 32'h123456ff, 1'b0},
    '{FMT_RGBA8888, 8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 1'b1, 32'hffffff00, 1'b1},
    '{FMT_RGBA8888, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 1'b1, 32'h000000ff, 1'b0},
    '{FMT_MONO1,    8'h80, 8'h80, 8'h80, 8'h00, 1'b0, 1'b1, 32'h1,        1'b0},
    '{FMT_MONO1,    8'h80, 8'h80, 8'h7f, 8'hff, 1'b0, 1'b1, 32'h0,        1'b0},
    '{FMT_YA11,     8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1, 32'h1,        1'b0},
    '{FMT_YA11,     8'hff, 8'hff, 8'hff, 8'h80, 1'b0, 1'b1, 32'h3,        1'b0},
    '{FMT_YA11,     8'h40, 8'h40, 8'h40, 8'hff, 1'b0, 1'b1, 32'h0,        1'b1},
    '{FMT_YA11,     8'hbf, 8'hbf, 8'hbf, 8'hff, 1'b1, 1'b1, 32'h0,        1'b1},
    '{FMT_YA11,     8'hc0, 8'hc0, 8'hc0, 8'hff, 1'b1, 1'b1, 32'h3,        1'b0},
    '{FMT_YA11,     8'h00, 8'h00, 8'h00, 8'h7f, 1'b0, 1'b1, 32'h0,        1'b1},
    '{FMT_BGR565,   8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 1'b1, 32'h0800,     1'b0},
    '{FMT_BGR565,   8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 32'hffff,     1'b0},
    '{FMT_BGR565,   8'h07, 8'h03, 8'h07, 8'h80, 1'b0, 1'b1, 32'h0800,     1'b0},
    '{FMT_BGR565,   8'hff, 8'hff, 8'hff, 8'h7f, 1'b0, 1'b1, 32'h0,        1'b1},
    '{FMT_Y8,       8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 1'b1, 32'hff,       1'b0},
    '{FMT_Y8,       8'h12, 8'h34, 8'h56, 8'ha5, 1'b0, 1'b0, 32'h0,        1'b0},
    '{FMT_BGR332,   8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1, 32'h20,       1'b0},
    '{FMT_BGR332,   8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 32'hff,       1'b0},
    '{FMT_BGR332,   8'h3f, 8'h1f, 8'h1f, 8'h80, 1'b0, 1'b1, 32'h20,       1'b0},
    '{FMT_BGR332,   8'h01, 8'h02, 8'h03, 8'h00, 1'b0, 1'b1, 32'h0,        1'b1},
    '{FMT_ARGB4444, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 32'hffff,     1'b0},
    '{FMT_ARGB4444, 8'h12, 8'h34, 8'h56, 8'h7f, 1'b0, 1'b1, 32'h7135,     1'b1},
    '{FmtUnused,    8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 32'h0,        1'b1},
    '{FmtUnused,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 32'h0,        1'b0}
  };

  rgba_pixel_format_converter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .alpha_i       (alpha_i),
    .image_start_i (image_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_code_o  (pixel_code_o),
    .alpha_seen_o  (alpha_seen_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run must never get near this; reaching it means the block hung.
  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Converts one pixel in the current format and updates the sticky flag.
  function automatic conv_result_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [7:0] a,
                                                 input logic start);
    int unsigned sum;
    int unsigned avg;
    logic [31:0] code;
    if (start) begin
      seen_flag = 1'b0;
    end
    sum = r + g + b;
    avg = sum / 3;
    code = '0;
    case (cur_format)
      FMT_MONO1: begin
        code = (sum >= 384) ? 32'd1 : 32'd0;
      end
      FMT_YA11: begin
        if (a < 8'h80 || (avg >= 'h40 && avg < 'hc0)) begin
          code = '0;
          seen_flag = 1'b1;
        end else begin
          code = (avg < 'h80) ? 32'd1 : 32'd3;
        end
      end
      FMT_BGR565: begin
        code = {16'd0, b[7:3], g[7:2], r[7:3]};
        if (a < 8'h80) begin
          code = '0;
          seen_flag = 1'b1;
        end else if (code == '0) begin
          code = 32'h0800;
        end
      end
      FMT_RGBA8888: begin
        if (a == 8'h00) begin
          seen_flag = 1'b1;
        end
        code = {r, g, b, a};
      end
      FMT_Y8: begin
        code = avg;
      end
      FMT_BGR332: begin
        code = {24'd0, b[7:5], g[7:5], r[7:6]};
        if (a < 8'h80) begin
          code = '0;
          seen_flag = 1'b1;
        end else if (code == '0) begin
          code = 32'h20;
        end
      end
      FMT_ARGB4444: begin
        if (a < 8'h80) begin
          seen_flag = 1'b1;
        end
        code = {16'd0, a[7:4], r[7:4], g[7:4], b[7:4]};
      end
      default: begin
        code = '0;
      end
    endcase
    return '{code: code, seen: seen_flag};
  endfunction

  // Channel value that favors the thresholds of the conversions.
  function automatic logic [7:0] pick_level();
    logic [7:0] edges [10] = '{8'h00, 8'h01, 8'h3f, 8'h40, 8'h7f,
                               8'h80, 8'hbf, 8'hc0, 8'hfe, 8'hff};
    if ($urandom_range(0, 99) < 30) begin
      return edges[$urandom_range(0, 9)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one pixel word, holds it until accepted, then queues its expected result.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] a, input logic start,
                            input logic has_exp, input conv_result_t typed);
    conv_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    alpha_i       <= a;
    image_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    res = convert_pixel(r, g, b, a, start);
    pending_codes.push_back(has_exp ? typed : res);
  endtask

  // Writes the format register once the pipeline has drained.
  task automatic set_format(input logic [2:0] fmt);
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fmt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_format = fmt;
  endtask

  // Receiver backpressure.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    conv_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected result word: pixel_code %h alpha_seen %b",
               pixel_code_o, alpha_seen_o);
        mismatch_count++;
      end else begin
        want = pending_codes.pop_front();
        if (pixel_code_o !== want.code) begin
          $error("pixel_code mismatch: expected %h, got %h", want.code, pixel_code_o);
          mismatch_count++;
        end
        if (alpha_seen_o !== want.seen) begin
          $error("alpha_seen mismatch: expected %b, got %b", want.seen, alpha_seen_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs with a slow sender and a busy receiver.
    send_idle_pct = 23;
    stall_pct = 68;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fmt != cur_format) begin
        set_format(dir_rows[i].fmt);
      end
      send_pixel(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue, dir_rows[i].alpha,
                 dir_rows[i].start, dir_rows[i].has_exp,
                 '{code: dir_rows[i].code, seen: dir_rows[i].seen});
    end

    // Random part: every format under each idling pattern.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase / 8)
        0: begin
          send_idle_pct = 23;
          stall_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      set_format(3'(phase));
      for (int n = 0; n < PixelsPerPhase; n++) begin
        r = pick_level();
        if ($urandom_range(0, 3) == 0) begin
          // Gray pixels make the average equal the channel level, so edge levels land on the thresholds.
          g = r;
          b = r;
        end else begin
          g = pick_level();
          b = pick_level();
        end
        a = pick_level();
        send_pixel(r, g, b, a, ($urandom_range(0, 15) == 0), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rpfc_pkg.sv
rtl/rpfc_convert.sv
rtl/rgba_pixel_format_converter_top.sv
tb/rgba_pixel_format_converter_top_tb.sv
